// ----- rtl/f2pcm_pkg.sv -----
// Package: format codes, config indexes and shared types for the float-to-PCM converter.
package f2pcm_pkg;

  typedef enum logic [2:0] {
    FMT_INT16 = 3'd0,
    FMT_INT24 = 3'd1,
    FMT_INT32 = 3'd2,
    FMT_F32   = 3'd3,
    FMT_F64   = 3'd4
  } fmt_t;

  localparam logic CFG_CHAN0 = 1'b0;
  localparam logic CFG_CHAN1 = 1'b1;

  // Scale factors as integers
  localparam logic [30:0] SCALE16 = 31'd32767;
  localparam logic [30:0] SCALE24 = 31'd8388607;
  localparam logic [30:0] SCALE32 = 31'd2147483647;

  // Decoded sample, carried from the input register to the converter
  typedef struct packed {
    logic        is_nan;
    logic        sign;
    logic [7:0]  exp;
    logic [22:0] frac;
    logic [31:0] bits;
    logic [2:0]  fmt;
    logic        last;
  } samp_t;

endpackage

// ----- rtl/f2pcm_cfg.sv -----
// Format registers for the two channels and their write port.
module f2pcm_cfg (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [2:0] cfg_data,
  output logic [2:0] fmt0,
  output logic [2:0] fmt1
);

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt0 <= 3'd0;
      fmt1 <= 3'd0;
    end else if (cfg_valid) begin
      if (cfg_index == f2pcm_pkg::CFG_CHAN0) fmt0 <= cfg_data;
      else fmt1 <= cfg_data;
    end
  end

endmodule

// ----- rtl/f2pcm_conv.sv -----
// Combinational clamp and conversion of one registered sample.
module f2pcm_conv (
  input  f2pcm_pkg::samp_t s,
  output logic [63:0]      word,
  output logic [3:0]       count
);

  logic        big;      // |x| >= 1 (clamped to magnitude 1)
  logic        zero;     // magnitude below the smallest normal
  logic [23:0] mant;     // 1.frac
  logic [7:0]  sh;       // right shift of 1.0 position, 1..
  logic [31:0] cbits;    // clamped float32 bits
  logic [30:0] scale;
  logic [54:0] prod;     // mant * scale
  logic [54:0] rnd;
  logic [54:0] lsb;
  logic [54:0] half;
  logic [54:0] fixed;    // value << 23 after rounding, magnitude
  logic [31:0] mag;
  logic [31:0] sval;
  logic [5:0]  plen;
  logic [10:0] dexp;
  logic [22:0] dfrac;
  logic [4:0]  lz;

  always_comb begin
    big   = (s.exp >= 8'd127);
    zero  = (s.exp == 8'd0);
    cbits = big ? {s.sign, 8'd127, 23'd0} : s.bits;
    mant  = {1'b1, s.frac};
    sh    = 8'd127 - s.exp;
    unique case (s.fmt)
      f2pcm_pkg::FMT_INT16: scale = f2pcm_pkg::SCALE16;
      f2pcm_pkg::FMT_INT24: scale = f2pcm_pkg::SCALE24;
      default:              scale = f2pcm_pkg::SCALE32;
    endcase
    prod = big ? {1'b0, scale, 23'd0} : 55'(mant) * 55'(scale);
    // bit length of product
    plen = 6'd0;
    for (int i = 0; i < 55; i++) if (prod[i]) plen = 6'(i + 1);
    // float32 rounding for int16/int24 keeps 24 bits; the int32 product is not exact in double
    // (24+31=55 bits > 53) so it is rounded to 53 bits
    lsb  = 55'd0;
    half = 55'd0;
    if (s.fmt == f2pcm_pkg::FMT_INT32) begin
      if (plen > 6'd53) begin
        lsb  = 55'd1 << (plen - 6'd53);
        half = 55'd1 << (plen - 6'd54);
      end
    end else if (plen > 6'd24) begin
      lsb  = 55'd1 << (plen - 6'd24);
      half = 55'd1 << (plen - 6'd25);
    end
    rnd = prod;
    if (lsb != 55'd0) begin
      rnd = prod & ~(lsb - 55'd1);
      if (((prod & (lsb - 55'd1)) > half) ||
          (((prod & (lsb - 55'd1)) == half) && ((prod & lsb) != 55'd0)))
        rnd = rnd + lsb;
    end
    fixed = big ? rnd : (rnd >> (sh[5:0]));
    if (!big && (sh > 8'd54)) fixed = 55'd0;
    mag   = fixed[54:23];
    if (zero) mag = 32'd0;
    sval  = s.sign ? (32'd0 - mag) : mag;
    if (s.is_nan) sval = 32'd0;
    // exact widening of the clamped value (denormals normalized)
    lz = 5'd0;
    for (int i = 0; i < 23; i++) if (s.frac[i]) lz = 5'(22 - i);
    if (big) begin
      dexp = 11'd1023; dfrac = 23'd0;
    end else if (zero) begin
      dexp  = (s.frac == 23'd0) ? 11'd0 : 11'd896 - 11'(lz);
      dfrac = (s.frac << (lz + 5'd1));
    end else begin
      dexp = 11'(s.exp) + 11'd896; dfrac = s.frac;
    end
    word  = 64'd0;
    count = 4'd0;
    unique case (s.fmt)
      f2pcm_pkg::FMT_INT16: begin word = {48'd0, sval[15:0]}; count = 4'd2; end
      f2pcm_pkg::FMT_INT24: begin word = {40'd0, sval[23:0]}; count = 4'd3; end
      f2pcm_pkg::FMT_INT32: begin word = {32'd0, sval}; count = 4'd4; end
      f2pcm_pkg::FMT_F32: begin
        word = {32'd0, s.is_nan ? s.bits : cbits}; count = 4'd4;
      end
      f2pcm_pkg::FMT_F64: begin
        word = s.is_nan ? {s.sign, 11'h7FF, 1'b1, s.frac[21:0], 29'd0} |
                          {12'd0, s.frac[22], 51'd0}
                        : {s.sign, dexp, dfrac, 29'd0};
        count = 4'd8;
      end
      default: begin word = 64'd0; count = 4'd0; end
    endcase
  end

endmodule

// ----- rtl/float_to_pcm_sample_converter_unit.sv -----
// Top level: input register, converter, output register with handshakes.
//  channel | signals                                   | dir
//  in      | in_valid in_ready sample_bits chan_sel last_in | sink
//  out     | out_valid out_ready packed_word byte_count last_out | source
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | sink
// Input transfer loads the input register, which feeds the result register. One item
// per clock while out_ready is high, set by the single converter stage.
// Reset clears both valid flags and the format registers to int16.
// A stalled output holds both stages; the input register moves when the output frees.
module float_to_pcm_sample_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  input  logic        chan_sel,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] packed_word,
  output logic [3:0]  byte_count,
  output logic        last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  logic [2:0] fmt0, fmt1;
  f2pcm_pkg::samp_t stage, stage_next;
  logic       stage_valid;
  logic       stage_ready;
  logic [63:0] word;
  logic [3:0]  count;

  f2pcm_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fmt0, .fmt1
  );

  // Decode on input
  always_comb begin
    stage_next.is_nan = (sample_bits[30:0] > 31'h7F800000);
    stage_next.sign   = sample_bits[31];
    stage_next.exp    = sample_bits[30:23];
    stage_next.frac   = sample_bits[22:0];
    stage_next.bits   = sample_bits;
    stage_next.fmt    = chan_sel ? fmt1 : fmt0;
    stage_next.last   = last_in;
  end

  assign stage_ready = !out_valid || out_ready;
  assign in_ready    = !stage_valid || stage_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) stage_valid <= 1'b0;
    else if (in_ready) stage_valid <= in_valid;
    if (in_ready && in_valid) stage <= stage_next;
  end

  f2pcm_conv u_conv (.s(stage), .word, .count);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (stage_ready) out_valid <= stage_valid;
    if (stage_ready && stage_valid) begin
      packed_word <= word;
      byte_count  <= count;
      last_out    <= stage.last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packed_word)) else $error("hold");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count == 4'd0 || byte_count == 4'd2 || byte_count == 4'd3 ||
                   byte_count == 4'd4 || byte_count == 4'd8)) else $error("count");
  a_move: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_ready |=> out_valid) else $error("move");

endmodule

// ----- sim/tb_float_to_pcm_sample_converter_unit.sv -----
// Testbench for the float-to-PCM sample converter: directed and random samples, checked in order.
module tb_float_to_pcm_sample_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } pcm_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] sample_bits;
  logic        chan_sel;
  logic        last_in;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] packed_word;
  logic [3:0]  byte_count;
  logic        last_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [2:0]  cfg_data;

  // shadow format registers and pending results
  logic [2:0] fmt_shadow [2];
  pcm_t       pending_pcm [$];
  int         mismatches;
  int         hold_cycles;
  bit         no_idle;

  float_to_pcm_sample_converter_unit dut (.*);

  // clock and reset
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // float32 multiply by k (round to nearest even), then truncate toward zero
  function automatic logic [31:0] scale_trunc(logic [31:0] f, longint unsigned k);
    longint unsigned m, p, q, rem, half;
    int e, nb, sh;
    logic [31:0] v;
    if (f[30:23] == 8'd0) begin
      m = f[22:0];
      e = -149;
    end else begin
      m = {1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
    p = m * k;
    nb = 0;
    for (int i = 0; i < 64; i++) if (p[i]) nb = i + 1;
    if (nb > 24) begin
      sh = nb - 24;
      q = p >> sh;
      rem = p & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      p = q << sh;
    end
    q = (-e >= 64) ? 64'd0 : (p >> (-e));
    v = q[31:0];
    if (f[31]) v = -v;
    return v;
  endfunction

  // exact float32 -> float64 widening for non-NaN, finite values
  function automatic logic [63:0] widen(logic [31:0] f);
    logic [23:0] fr;
    int n;
    logic [10:0] ed;
    if (f[30:0] == 31'd0) return {f[31], 63'd0};
    if (f[30:23] == 8'd0) begin
      fr = {1'b0, f[22:0]};
      n = 0;
      while (!fr[23]) begin
        fr = fr << 1;
        n++;
      end
      ed = 11'(1023 - 126 - n);
      return {f[31], ed, fr[22:0], 29'd0};
    end
    ed = 11'(int'(f[30:23]) - 127 + 1023);
    return {f[31], ed, f[22:0], 29'd0};
  endfunction

  function automatic pcm_t convert_sample(logic [31:0] bits, logic ch, logic lst);
    pcm_t r;
    logic [2:0] fmt;
    logic nan;
    logic [31:0] s;
    logic [31:0] v;
    real d;
    fmt = fmt_shadow[ch];
    nan = bits[30:0] > 31'h7F800000;
    s = bits;
    // clamp to [-1, 1]; infinities land here too
    if (!nan && bits[30:0] > 31'h3F800000) s = {bits[31], 31'h3F800000};
    r.last = lst;
    r.word = 64'd0;
    case (fmt)
      f2pcm_pkg::FMT_INT16: begin
        v = nan ? 32'd0 : scale_trunc(s, 64'd32767);
        r.word = {48'd0, v[15:0]};
        r.nbytes = 4'd2;
      end
      f2pcm_pkg::FMT_INT24: begin
        v = nan ? 32'd0 : scale_trunc(s, 64'd8388607);
        r.word = {40'd0, v[23:0]};
        r.nbytes = 4'd3;
      end
      f2pcm_pkg::FMT_INT32: begin
        d = $bitstoreal(widen(s)) * 2147483647.0;
        v = nan ? 32'd0 : $rtoi(d);
        r.word = {32'd0, v};
        r.nbytes = 4'd4;
      end
      f2pcm_pkg::FMT_F32: begin
        r.word = {32'd0, s};
        r.nbytes = 4'd4;
      end
      f2pcm_pkg::FMT_F64: begin
        // NaN widens with the quiet bit forced
        r.word = nan ? ({bits[31], 11'h7FF, 1'b1, bits[21:0], 29'd0} |
                        {12'd0, bits[22], 51'd0}) : widen(s);
        r.nbytes = 4'd8;
      end
      default: r.nbytes = 4'd0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // input/config transfers feed the predictor; output transfers are checked
  always @(posedge clk) begin
    pcm_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) fmt_shadow[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        pending_pcm.insert(pending_pcm.size(),
                           convert_sample(sample_bits, chan_sel, last_in));
      if (out_valid && out_ready) begin
        if (pending_pcm.size() == 0) begin
          report_mismatch("unexpected result", packed_word, 64'd0);
        end else begin
          e = pending_pcm.pop_front();
          if (packed_word !== e.word) report_mismatch("packed_word", packed_word, e.word);
          if (byte_count !== e.nbytes) report_mismatch("byte_count", byte_count, e.nbytes);
          if (last_out !== e.last) report_mismatch("last_out", last_out, e.last);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int idle_left;
    idle_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle) idle_left = pick_gap();
      end
    end
  end

  // one input transfer, then a random gap
  task automatic send_sample(logic [31:0] bits, logic ch, logic lst);
    int gap;
    in_valid <= 1'b1;
    sample_bits <= bits;
    chan_sel <= ch;
    last_in <= lst;
    do @(posedge clk); while (!(in_valid && in_ready));
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(logic [0:0] idx, logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
    if (r < 80) return {1'($urandom), 8'($urandom_range(125, 127)), 23'($urandom)};
    return $urandom;
  endfunction

  // directed edge values through every format code, both channels
  task automatic test_edge_values();
    logic [31:0] vals [18];
    vals = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h40000000,
             32'hC2C80000, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h7F800001,
             32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF, 32'h3F7FFFFF, 32'hBF000000,
             32'h3F000001, 32'h7F7FFFFF, 32'h38000100};
    for (int f = 0; f < 8; f++) begin
      write_format(f2pcm_pkg::CFG_CHAN0, 3'(f));
      write_format(f2pcm_pkg::CFG_CHAN1, 3'(7 - f));
      for (int i = 0; i < 18; i++) send_sample(vals[i], 1'(i), 1'(i == 17));
      drain();
    end
  endtask

  // random samples with format changes between phases
  task automatic test_random_stream();
    for (int ph = 0; ph < 6; ph++) begin
      write_format(f2pcm_pkg::CFG_CHAN0,
                   ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)));
      write_format(f2pcm_pkg::CFG_CHAN1, 3'($urandom_range(0, 4)));
      no_idle = (ph == 2);
      for (int i = 0; i < 70; i++) send_sample(rand_sample(), 1'($urandom), 1'($urandom));
      drain();
    end
    no_idle = 1'b0;
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    write_format(f2pcm_pkg::CFG_CHAN0, f2pcm_pkg::FMT_F64);
    write_format(f2pcm_pkg::CFG_CHAN1, f2pcm_pkg::FMT_INT24);
    hold_cycles = 200;
    no_idle = 1'b1;
    for (int i = 0; i < 30; i++) send_sample(rand_sample(), 1'($urandom), 1'($urandom));
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    mismatches = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    fmt_shadow[0] = f2pcm_pkg::FMT_INT16;
    fmt_shadow[1] = f2pcm_pkg::FMT_INT16;
    in_valid = 1'b0;
    sample_bits = 32'd0;
    chan_sel = 1'b0;
    last_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = f2pcm_pkg::CFG_CHAN0;
    cfg_data = 3'd0;
    @(posedge clk);
    while (rst) @(posedge clk);
    // reset formats are int16 on both channels
    send_sample(32'h3F000000, 1'b0, 1'b0);
    send_sample(32'hBF800000, 1'b1, 1'b1);
    drain();
    test_edge_values();
    test_backpressure();
    test_random_stream();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- float_to_pcm_sample_converter_unit.f -----
rtl/f2pcm_pkg.sv
rtl/f2pcm_cfg.sv
rtl/f2pcm_conv.sv
rtl/float_to_pcm_sample_converter_unit.sv
sim/tb_float_to_pcm_sample_converter_unit.sv
